>>> rtl/sorted_priority_queue_macros.svh
// Assertion macros used by the sorted priority queue datapath (spq_dp).
// Needs a clock and an active-low reset name at each use.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SPQ_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies.
package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int PRIO_W       = 8;
    localparam int OCC_W        = 5;
    localparam int STATUS_W     = 2;
    localparam int S_TDATA_W    = 40;
    localparam int M_TDATA_W    = 48;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNDERFLOW = 2'd1,
        STATUS_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_DELETE = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_DELETE,
        OP_OVERFLOW,
        OP_UNDERFLOW
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } dp_stat_t;

endpackage

>>> rtl/sorted_priority_queue.sv
// Sorted priority queue: entries stay in ascending priority value, equal priorities in
// arrival order; each word is an insert or a delete of the head and yields one result
// word in the cycle after it is taken. Insert compares every stored cell with the new
// priority in parallel and shifts the tail up in that cycle; delete shifts each cell but
// the last down. The queue takes one word per cycle while results are taken, since the
// output register frees as its word leaves. Inserts into a full queue report overflow,
// deletes from an empty one underflow. Top level; depends on spq_pkg, spq_ctrl, spq_dp.
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [spq_pkg::S_TDATA_W-1:0] s_tdata,  // item_value[31:0], item_priority[39:32]
    input  logic [0:0]                    s_tuser,  // kind[0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [spq_pkg::M_TDATA_W-1:0] m_tdata,  // removed_value[31:0],
                                                    // removed_priority[39:32], occupancy[44:40]
    output logic [spq_pkg::STATUS_W-1:0]  m_tuser   // status[1:0]
);
    import spq_pkg::*;

    dp_cmd_t             cmd;
    dp_stat_t            stat;
    logic [STATUS_W-1:0] res_status;
    logic [VALUE_W-1:0]  res_value;
    logic [PRIO_W-1:0]   res_prio;
    logic [OCC_W-1:0]    res_occ;

    spq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_value   (s_tdata[VALUE_W-1:0]),
        .in_prio    (s_tdata[VALUE_W+PRIO_W-1:VALUE_W]),
        .res_status (res_status),
        .res_value  (res_value),
        .res_prio   (res_prio),
        .res_occ    (res_occ)
    );

    assign m_tdata = {(M_TDATA_W - VALUE_W - PRIO_W - OCC_W)'(0), res_occ, res_prio, res_value};
    assign m_tuser = res_status;

endmodule

>>> rtl/spq_ctrl.sv
// Handshake controller for the sorted priority queue.
// Depends on spq_pkg; drives commands into spq_dp.
module spq_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             s_kind,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  spq_pkg::dp_stat_t stat,
    output spq_pkg::dp_cmd_t  cmd
);
    import spq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE) || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_HOLD);

    always_comb begin
        cmd.op = OP_NONE;
        if (accept) begin
            unique case (kind_t'(s_kind))
                KIND_INSERT: cmd.op = stat.full  ? OP_OVERFLOW  : OP_INSERT;
                KIND_DELETE: cmd.op = stat.empty ? OP_UNDERFLOW : OP_DELETE;
                default:     cmd.op = OP_NONE;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_HOLD;
            ST_HOLD: if (m_tready && !accept) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/spq_dp.sv
// Datapath for the sorted priority queue: sorted row of entry cells and result register.
// Depends on spq_pkg and sorted_priority_queue_macros.svh; commanded by spq_ctrl.
module spq_dp #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  spq_pkg::dp_cmd_t             cmd,
    output spq_pkg::dp_stat_t            stat,
    input  logic [spq_pkg::VALUE_W-1:0]  in_value,
    input  logic [spq_pkg::PRIO_W-1:0]   in_prio,
    output logic [spq_pkg::STATUS_W-1:0] res_status,
    output logic [spq_pkg::VALUE_W-1:0]  res_value,
    output logic [spq_pkg::PRIO_W-1:0]   res_prio,
    output logic [spq_pkg::OCC_W-1:0]    res_occ
);
    import spq_pkg::*;
    `include "sorted_priority_queue_macros.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [VALUE_W-1:0] val_reg  [CAPACITY];
    logic [PRIO_W-1:0]  prio_reg [CAPACITY];
    logic [CAPACITY-1:0] le;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    status_t            status_reg;
    status_t            status_next;
    logic [VALUE_W-1:0] rval_reg;
    logic [VALUE_W-1:0] rval_next;
    logic [PRIO_W-1:0]  rprio_reg;
    logic [PRIO_W-1:0]  rprio_next;
    logic               res_load;

    assign stat.full  = (count_reg == CNT_W'(CAPACITY));
    assign stat.empty = (count_reg == '0);

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        assign le[i] = (CNT_W'(i) < count_reg) && (prio_reg[i] <= in_prio);

        always_ff @(posedge aclk) begin
            if (cmd.op == OP_INSERT && !le[i]) begin
                if (i == 0) begin
                    val_reg[i]  <= in_value;
                    prio_reg[i] <= in_prio;
                end else if (le[(i == 0) ? 0 : i - 1]) begin
                    val_reg[i]  <= in_value;
                    prio_reg[i] <= in_prio;
                end else begin
                    val_reg[i]  <= val_reg[(i == 0) ? 0 : i - 1];
                    prio_reg[i] <= prio_reg[(i == 0) ? 0 : i - 1];
                end
            end else if (cmd.op == OP_DELETE && i < CAPACITY - 1) begin
                val_reg[i]  <= val_reg[(i < CAPACITY - 1) ? i + 1 : i];
                prio_reg[i] <= prio_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    always_comb begin
        count_next  = count_reg;
        status_next = status_reg;
        rval_next   = rval_reg;
        rprio_next  = rprio_reg;
        res_load    = 1'b1;
        unique case (cmd.op)
            OP_INSERT: begin
                count_next  = count_reg + CNT_W'(1);
                status_next = STATUS_OK;
                rval_next   = '0;
                rprio_next  = '0;
            end
            OP_DELETE: begin
                count_next  = count_reg - CNT_W'(1);
                status_next = STATUS_OK;
                rval_next   = val_reg[0];
                rprio_next  = prio_reg[0];
            end
            OP_OVERFLOW: begin
                status_next = STATUS_OVERFLOW;
                rval_next   = '0;
                rprio_next  = '0;
            end
            OP_UNDERFLOW: begin
                status_next = STATUS_UNDERFLOW;
                rval_next   = '0;
                rprio_next  = '0;
            end
            default: res_load = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            status_reg <= status_next;
            rval_reg   <= rval_next;
            rprio_reg  <= rprio_next;
        end
    end

    assign res_status = status_reg;
    assign res_value  = rval_reg;
    assign res_prio   = rprio_reg;
    assign res_occ    = OCC_W'(count_reg);

    `SPQ_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(CAPACITY), "count exceeds capacity")
    `SPQ_ASSERT_NXT(a_insert_grows, aclk, aresetn, cmd.op == OP_INSERT, count_reg == $past(count_reg) + CNT_W'(1), "insert did not grow count")
    `SPQ_ASSERT_IMP(a_head_sorted, aclk, aresetn, count_reg >= CNT_W'(2), prio_reg[0] <= prio_reg[1], "head pair out of order")
    `SPQ_ASSERT_NXT(a_reject_zero, aclk, aresetn, cmd.op == OP_OVERFLOW || cmd.op == OP_UNDERFLOW, rval_reg == '0 && rprio_reg == '0 && count_reg == $past(count_reg), "rejected op changed state")

endmodule
